// ----- rtl/sha1_pkg.sv -----
// ----------------------------------------------------------------------------
// sha1_pkg
// shared types and constants for the sha-1 digest engine
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int WORDS = 5;

  typedef logic [WORDS-1:0][31:0] words_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        is_final;
  } result_t;

  typedef struct packed {
    logic       shift;
    logic [7:0] data;
    logic       step;
  } sched_ctl_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [6:0] rnd;
  } round_ctl_t;

  localparam words_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                               32'hEFCDAB89, 32'h67452301};

  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [6:0] ROUND_P1   = 7'd20;
  localparam logic [6:0] ROUND_P2   = 7'd40;
  localparam logic [6:0] ROUND_P3   = 7'd60;

  localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

// ----- rtl/sha1_sched.sv -----
// ----------------------------------------------------------------------------
// sha1_sched
// block buffer and message schedule: bytes shift in, then the
// 16-word window slides one word per round
// ----------------------------------------------------------------------------
module sha1_sched (
  input  logic                  clk,
  input  sha1_pkg::sched_ctl_t  ctl,
  output logic [31:0]           w
);
  import sha1_pkg::*;

  // blk[15] holds the oldest word
  logic [15:0][31:0] blk;
  logic [31:0]       mix;
  logic [31:0]       w_new;

  assign mix   = blk[15] ^ blk[13] ^ blk[7] ^ blk[2];
  assign w_new = {mix[30:0], mix[31]};
  assign w     = blk[15];

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      blk <= 512'({blk, ctl.data});
    end else if (ctl.step) begin
      blk <= {blk[14:0], w_new};
    end
  end

endmodule

// ----- rtl/sha1_round.sv -----
// ----------------------------------------------------------------------------
// sha1_round
// working variables a..e and the shared round unit, one round per cycle
// ----------------------------------------------------------------------------
module sha1_round (
  input  logic                  clk,
  input  sha1_pkg::round_ctl_t  ctl,
  input  sha1_pkg::words_t      chain,
  input  logic [31:0]           w,
  output sha1_pkg::words_t      st
);
  import sha1_pkg::*;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  logic [31:0] a, b, c, d, e;
  logic [31:0] f, k, t;

  assign a = st[0];
  assign b = st[1];
  assign c = st[2];
  assign d = st[3];
  assign e = st[4];

  always_comb begin
    priority if (ctl.rnd < ROUND_P1) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (ctl.rnd < ROUND_P2) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (ctl.rnd < ROUND_P3) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign t = {a[26:0], a[31:27]} + f + e + k + w;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      st <= chain;
    end else if (ctl.step) begin
      st <= {d, c, {b[1:0], b[31:2]}, a, t};
    end
  end

endmodule

// ----- rtl/sha1_hash_engine_core.sv -----
// ----------------------------------------------------------------------------
// sha1_hash_engine_core
// streaming sha-1: one message byte per word in, five digest words out
// ----------------------------------------------------------------------------
//  channel  | ports                             | payload
//  ---------+-----------------------------------+---------------------------
//  item     | item_valid, item_stall, item      | data_byte, has_byte, is_last
//  result   | result_valid, result_stall, result| digest_word, word_index,
//           |                                   | is_final
//
//  a byte word is accepted while idle; the word that fills a 64-byte block starts
//  a compression (80 rounds through one round unit, then the chaining add)
//  a word with is_last adds padding at one byte per cycle outside compressions,
//  one or two compressions, then five result words
//  item_stall is high whenever the sequencer is not idle
//  a stalled result word holds until taken
//  rst is synchronous and restores the initial chaining words and zero count
// ----------------------------------------------------------------------------
module sha1_hash_engine_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  sha1_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output sha1_pkg::result_t result
);
  import sha1_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [2:0] IDX_LAST  = 3'd4;

  logic [2:0]  state;
  logic [5:0]  fill;
  logic [60:0] count;
  logic [6:0]  rnd;
  logic [2:0]  idx;
  logic        pad_on;
  logic        sent80;
  logic        hi80;
  logic        finish;
  words_t      chain;
  words_t      st;

  logic        acc;
  logic        pad_shift;
  logic        len_here;
  logic        block_full;
  logic [63:0] len_bits;
  logic [2:0]  len_sel;
  logic [7:0]  len_byte;
  logic [7:0]  pad_byte;
  logic [31:0] w;
  sched_ctl_t  sctl;
  round_ctl_t  rctl;

  assign acc        = item_valid && (state == S_IDLE);
  assign item_stall = (state != S_IDLE);
  assign pad_shift  = (state == S_PAD);

  assign len_bits = {count, 3'b000};
  assign len_sel  = ~fill[2:0];
  assign len_byte = len_bits[{len_sel, 3'b000} +: 8];
  assign len_here = sent80 && !hi80 && (fill >= LEN_POS);

  always_comb begin
    if (!sent80) begin
      pad_byte = PAD_MARK;
    end else if (len_here) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign sctl.shift = (acc && item.has_byte) || pad_shift;
  assign sctl.data  = pad_shift ? pad_byte : item.data_byte;
  assign sctl.step  = (state == S_ROUND);

  assign block_full = sctl.shift && (fill == FILL_LAST);

  assign rctl.load = block_full;
  assign rctl.step = (state == S_ROUND);
  assign rctl.rnd  = rnd;

  sha1_sched u_sched (
    .clk (clk),
    .ctl (sctl),
    .w   (w)
  );

  sha1_round u_round (
    .clk   (clk),
    .ctl   (rctl),
    .chain (chain),
    .w     (w),
    .st    (st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      chain  <= H_INIT;
      count  <= '0;
      fill   <= '0;
      rnd    <= '0;
      idx    <= '0;
      pad_on <= 1'b0;
      sent80 <= 1'b0;
      hi80   <= 1'b0;
      finish <= 1'b0;
    end else begin
      if (sctl.shift) begin
        fill <= fill + 6'd1;
      end
      if (block_full) begin
        rnd <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (item.has_byte) begin
              count <= count + 61'd1;
            end
            pad_on <= item.is_last;
            sent80 <= 1'b0;
            hi80   <= 1'b0;
            finish <= 1'b0;
            if (block_full) begin
              state <= S_ROUND;
            end else if (item.is_last) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          sent80 <= 1'b1;
          if (fill == FILL_LAST) begin
            hi80 <= 1'b0;
          end else if (!sent80 && (fill >= LEN_POS)) begin
            hi80 <= 1'b1;
          end
          if (fill == FILL_LAST) begin
            if (len_here) begin
              finish <= 1'b1;
            end
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          rnd <= rnd + 7'd1;
          if (rnd == ROUND_LAST) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < WORDS; i++) begin
            chain[i] <= chain[i] + st[i];
          end
          idx <= '0;
          if (finish) begin
            state <= S_EMIT;
          end else if (pad_on) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!result_stall) begin
            idx <= idx + 3'd1;
            if (idx == IDX_LAST) begin
              chain  <= H_INIT;
              count  <= '0;
              pad_on <= 1'b0;
              sent80 <= 1'b0;
              finish <= 1'b0;
              state  <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result_valid       = (state == S_EMIT);
  assign result.digest_word = chain[idx];
  assign result.word_index  = idx;
  assign result.is_final    = (idx == IDX_LAST);

endmodule

// ----- rtl/sha1_check.sv -----
// ----------------------------------------------------------------------------
// sha1_check
// port-level checks on the digest engine's result sequence
// ----------------------------------------------------------------------------
module sha1_check (
  input logic              clk,
  input logic              rst,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input sha1_pkg::result_t result
);
  import sha1_pkg::*;

  // a waiting digest word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // no new byte is taken while the digest goes out
  a_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("input open during digest output");

  // final mark sits on word four only
  a_final: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.is_final == (result.word_index == 3'd4)))
    else $error("final mark on wrong word");

  // words follow in order without gaps
  a_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !result.is_final |=>
      result_valid && (result.word_index == 3'($past(result.word_index) + 3'd1)))
    else $error("digest word order broken");

  // output ends after the final word
  a_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && result.is_final |=> !result_valid)
    else $error("output continues after final word");

endmodule

bind sha1_hash_engine_core sha1_check u_sha1_check (.*);
